[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[src/dreg_pkg.sv]
// ----------------------------------------------------------------------------
// Device registry package
// Shared types, codes and constants of the device registry search unit.
// ----------------------------------------------------------------------------
package dreg_pkg;

	localparam int NTH_W   = 6;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;
	localparam int BASE_W  = 48;

	localparam logic [7:0] WILDCARD = 8'hFF;

	typedef enum logic [1:0] {
		FN_REGISTER   = 2'd0,
		FN_GET        = 2'd1,
		FN_FIND_ID    = 2'd2,
		FN_FIND_CLASS = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		logic [15:0]       vendor;
		logic [15:0]       device;
		logic [7:0]        cls;
		logic [7:0]        sub;
		logic [7:0]        ifc;
		logic [BASE_W-1:0] base;
		logic [7:0]        irq;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		func_t             func;
		entry_t            ent;
		logic [NTH_W-1:0]  nth;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		entry_t             ent;
		logic [COUNT_W-1:0] count;
	} res_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic do_reg;
		logic get_rd;
		logic get_res;
		logic scan_step;
		logic emit;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  scan_done;
		logic  out_free;
	} sts_t;

endpackage

[src/dreg_ifs.sv]
// ----------------------------------------------------------------------------
// Device registry channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dreg_req_if import dreg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [15:0]       vendor;
	logic [15:0]       device;
	logic [7:0]        class_code_in;
	logic [7:0]        subclass_in;
	logic [7:0]        interface_in;
	logic [BASE_W-1:0] base_in;
	logic [7:0]        irq_in;
	logic [NTH_W-1:0]  nth;

	modport source (output valid, func, vendor, device, class_code_in, subclass_in,
		interface_in, base_in, irq_in, nth, input ready);
	modport sink (input valid, func, vendor, device, class_code_in, subclass_in,
		interface_in, base_in, irq_in, nth, output ready);
endinterface

interface dreg_rsp_if import dreg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [SLOT_W-1:0]  slot;
	logic [15:0]        vendor_out;
	logic [15:0]        device_out;
	logic [7:0]         class_out;
	logic [7:0]         subclass_out;
	logic [7:0]         interface_out;
	logic [BASE_W-1:0]  base_out;
	logic [7:0]         irq_out;
	logic [COUNT_W-1:0] count;

	modport source (output valid, status, slot, vendor_out, device_out, class_out,
		subclass_out, interface_out, base_out, irq_out, count, input ready);
	modport sink (input valid, status, slot, vendor_out, device_out, class_out,
		subclass_out, interface_out, base_out, irq_out, count, output ready);
endinterface

[src/dreg_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dreg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[src/dreg_datapath.sv]
// ----------------------------------------------------------------------------
// Device registry datapath
// Request register, entry count, entry RAM, match scan and result registers.
// ----------------------------------------------------------------------------
module dreg_datapath import dreg_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	output sts_t sts,
	input  req_t req_in,
	input  logic rsp_ready,
	output logic rsp_valid,
	output res_t rsp_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = (CW > NTH_W) ? CW : NTH_W;

	req_t          req_q;
	res_t          res_q;
	res_t          rsp_q;
	logic          rsp_valid_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] rd_idx_s1;
	logic          rd_vld_s1;
	logic [NTH_W-1:0] found_q;

	logic          full;
	logic          get_ok;
	logic          issue;
	logic          hit;
	logic          done_match;
	logic          done_miss;
	logic          ram_we;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	entry_t        rdata;

	assign full   = (count_q == CW'(TABLE_DEPTH));
	assign get_ok = (WW'(req_q.nth) < WW'(count_q));
	assign issue  = cmd.scan_step && (idx_q < count_q);

	always_comb begin
		if (req_q.func == FN_FIND_ID)
			hit = (rdata.vendor == req_q.ent.vendor) && (rdata.device == req_q.ent.device);
		else
			hit = ((req_q.ent.cls == WILDCARD) || (rdata.cls == req_q.ent.cls)) &&
				((req_q.ent.sub == WILDCARD) || (rdata.sub == req_q.ent.sub)) &&
				((req_q.ent.ifc == WILDCARD) || (rdata.ifc == req_q.ent.ifc));
	end

	assign done_match = rd_vld_s1 && hit && (found_q == req_q.nth);
	assign done_miss  = !rd_vld_s1 && !(idx_q < count_q);

	assign ram_we    = cmd.do_reg && !full;
	assign ram_re    = issue || (cmd.get_rd && get_ok);
	assign ram_raddr = cmd.get_rd ? AW'(req_q.nth) : AW'(idx_q);

	dreg_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(count_q)),
		.wdata(req_q.ent),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req_in;
		if (cmd.do_reg) begin
			if (full) begin
				res_q.status <= ST_FULL;
				res_q.slot   <= '0;
				res_q.ent    <= '0;
				res_q.count  <= COUNT_W'(count_q);
			end else begin
				res_q.status <= ST_OK;
				res_q.slot   <= SLOT_W'(count_q);
				res_q.ent    <= req_q.ent;
				res_q.count  <= COUNT_W'(count_q + CW'(1));
			end
		end else if (cmd.get_res) begin
			res_q.status <= get_ok ? ST_OK : ST_NOT_FOUND;
			res_q.slot   <= get_ok ? SLOT_W'(req_q.nth) : '0;
			res_q.ent    <= get_ok ? rdata : '0;
			res_q.count  <= COUNT_W'(count_q);
		end else if (cmd.scan_step && (done_match || done_miss)) begin
			res_q.status <= done_match ? ST_OK : ST_NOT_FOUND;
			res_q.slot   <= done_match ? SLOT_W'(rd_idx_s1) : '0;
			res_q.ent    <= done_match ? rdata : '0;
			res_q.count  <= COUNT_W'(count_q);
		end
		if (cmd.emit)
			rsp_q <= res_q;
		rd_idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			found_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ram_we)
				count_q <= count_q + CW'(1);
			if (cmd.scan_clr) begin
				idx_q     <= '0;
				found_q   <= '0;
				rd_vld_s1 <= 1'b0;
			end else begin
				rd_vld_s1 <= issue;
				if (issue)
					idx_q <= idx_q + CW'(1);
				if (cmd.scan_step && rd_vld_s1 && hit && !done_match)
					found_q <= found_q + NTH_W'(1);
			end
			if (cmd.emit)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	assign sts.func      = req_q.func;
	assign sts.scan_done = done_match || done_miss;
	assign sts.out_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

[src/dreg_ctrl.sv]
// ----------------------------------------------------------------------------
// Device registry controller
// Sequences one request at a time through the datapath.
// ----------------------------------------------------------------------------
module dreg_ctrl import dreg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_REG      = 7'b0000100,
		S_GET_RD   = 7'b0001000,
		S_GET_RES  = 7'b0010000,
		S_SCAN     = 7'b0100000,
		S_EMIT     = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.scan_clr = 1'b1;
				case (sts.func)
					FN_REGISTER:               state_d = S_REG;
					FN_GET:                    state_d = S_GET_RD;
					FN_FIND_ID, FN_FIND_CLASS: state_d = S_SCAN;
					default:                   state_d = S_IDLE;
				endcase
			end
			S_REG: begin
				cmd.do_reg = 1'b1;
				state_d    = S_EMIT;
			end
			S_GET_RD: begin
				cmd.get_rd = 1'b1;
				state_d    = S_GET_RES;
			end
			S_GET_RES: begin
				cmd.get_res = 1'b1;
				state_d     = S_EMIT;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done)
					state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[src/device_registry_nth_match_unit.sv]
// ----------------------------------------------------------------------------
// Device registry with nth-match search
// Register and get: the request goes through dispatch, the register state (or the get read
// and get result states) and emit, which waits until the response register is free.
// Finds: one entry read per cycle from the entry RAM; one request is in flight at a time.
// Reset clears the entry count and control; table contents are left as is.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module device_registry_nth_match_unit import dreg_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	dreg_req_if.sink    req,
	dreg_rsp_if.source  rsp
);

	cmd_t cmd;
	sts_t sts;
	req_t req_data;
	res_t rsp_data;

	assign req_data.func       = func_t'(req.func);
	assign req_data.ent.vendor = req.vendor;
	assign req_data.ent.device = req.device;
	assign req_data.ent.cls    = req.class_code_in;
	assign req_data.ent.sub    = req.subclass_in;
	assign req_data.ent.ifc    = req.interface_in;
	assign req_data.ent.base   = req.base_in;
	assign req_data.ent.irq    = req.irq_in;
	assign req_data.nth        = req.nth;

	dreg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dreg_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_in   (req_data),
		.rsp_ready(rsp.ready),
		.rsp_valid(rsp.valid),
		.rsp_data (rsp_data)
	);

	assign rsp.status        = rsp_data.status;
	assign rsp.slot          = rsp_data.slot;
	assign rsp.vendor_out    = rsp_data.ent.vendor;
	assign rsp.device_out    = rsp_data.ent.device;
	assign rsp.class_out     = rsp_data.ent.cls;
	assign rsp.subclass_out  = rsp_data.ent.sub;
	assign rsp.interface_out = rsp_data.ent.ifc;
	assign rsp.base_out      = rsp_data.ent.base;
	assign rsp.irq_out       = rsp_data.ent.irq;
	assign rsp.count         = rsp_data.count;

	`ASSERT_IMPLY(a_emit_when_free, clk, arst_n, cmd.emit, sts.out_free)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`ASSERT_IMPLY(a_full_result, clk, arst_n, rsp.valid && (rsp.status == ST_FULL), (rsp.slot == '0) && (rsp.count == COUNT_W'(TABLE_DEPTH)))

endmodule
